[sv/pdd_pkg.sv]
// Shared constants and controller/datapath command type for the point motion block.
`timescale 1ns / 1ps
package pdd_pkg;

  localparam int COORD_WIDTH = 16;  // default coordinate width, signed fixed point
  localparam int TAG_WIDTH   = 16;
  localparam int NUM_AXES    = 3;

  // input item function codes
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_FLUSH  = 1'b1;

  // axis select codes for the shared squarer
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       load;       // capture a sample item, form deltas, update stored point
    logic       flush;      // clear stored point
    logic       square;     // square one axis delta and accumulate
    logic [1:0] sel;        // axis for square
    logic       root_init;  // load radicand, clear root and remainder
    logic       root_step;  // one bit of the square root
    logic       out_load;   // move finished item into output register
  } cmd_t;

endpackage

[sv/pdd_sample_if.sv]
// Input channel: one tagged point or a flush request per item.
`timescale 1ns / 1ps
interface pdd_sample_if #(
  parameter int W = pdd_pkg::COORD_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic signed [pdd_pkg::TAG_WIDTH-1:0] tag;
  logic signed [W-1:0]            x_coord;
  logic signed [W-1:0]            y_coord;
  logic signed [W-1:0]            z_coord;

  modport source (output valid, func, tag, x_coord, y_coord, z_coord, input ready);
  modport sink   (input valid, func, tag, x_coord, y_coord, z_coord, output ready);
endinterface

[sv/pdd_result_if.sv]
// Output channel: previous point, deltas, sign flags and distance per item.
`timescale 1ns / 1ps
interface pdd_result_if #(
  parameter int W = pdd_pkg::COORD_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [pdd_pkg::TAG_WIDTH-1:0] tag_out;
  logic signed [W-1:0]            before_x;
  logic signed [W-1:0]            before_y;
  logic signed [W-1:0]            before_z;
  logic [pdd_pkg::NUM_AXES-1:0]   rising_flags;
  logic signed [W:0]              delta_x;
  logic signed [W:0]              delta_y;
  logic signed [W:0]              delta_z;
  logic [W:0]                     distance;

  modport source (output valid, tag_out, before_x, before_y, before_z, rising_flags,
                  delta_x, delta_y, delta_z, distance, input ready);
  modport sink   (input valid, tag_out, before_x, before_y, before_z, rising_flags,
                  delta_x, delta_y, delta_z, distance, output ready);
endinterface

[sv/pdd_ctrl.sv]
// Controller: sequences capture, squaring, bit-serial square root and output load.
`timescale 1ns / 1ps
module pdd_ctrl #(
  parameter int W = pdd_pkg::COORD_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output pdd_pkg::cmd_t cmd
);

  localparam int CW = $clog2(W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQR  = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          out_full, out_full_next;
  logic          slot_free;

  assign slot_free = !out_full || out_ready;
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = out_full;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == pdd_pkg::FUNC_FLUSH) begin
            cmd.flush = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            cnt_next   = '0;
            state_next = ST_SQR;
          end
        end
      end
      ST_SQR: begin
        // one axis per cycle, then a final step that adds the last product
        if (cnt == CW'(pdd_pkg::NUM_AXES)) begin
          cmd.root_init = 1'b1;
          cnt_next      = '0;
          state_next    = ST_ROOT;
        end else begin
          cmd.square = 1'b1;
          cmd.sel    = cnt[1:0];
          cnt_next   = cnt + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == CW'(W)) begin
          state_next = ST_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end else begin
      out_full_next = out_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      out_full <= out_full_next;
    end
  end

endmodule

[sv/pdd_datapath.sv]
// Datapath: stored point, deltas, shared squarer, restoring square root, output register.
`timescale 1ns / 1ps
module pdd_datapath #(
  parameter int W = pdd_pkg::COORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pdd_pkg::cmd_t                       cmd,
  input  logic signed [pdd_pkg::TAG_WIDTH-1:0] tag,
  input  logic signed [W-1:0]                 x_coord,
  input  logic signed [W-1:0]                 y_coord,
  input  logic signed [W-1:0]                 z_coord,
  output logic signed [pdd_pkg::TAG_WIDTH-1:0] tag_out,
  output logic signed [W-1:0]                 before_x,
  output logic signed [W-1:0]                 before_y,
  output logic signed [W-1:0]                 before_z,
  output logic [pdd_pkg::NUM_AXES-1:0]        rising_flags,
  output logic signed [W:0]                   delta_x,
  output logic signed [W:0]                   delta_y,
  output logic signed [W:0]                   delta_z,
  output logic [W:0]                          distance
);

  localparam int SW = 2 * W + 2;  // sum of three squares stays below 2^SW

  logic signed [W-1:0] last_x, last_y, last_z;
  logic signed [pdd_pkg::TAG_WIDTH-1:0] tag_r;
  logic signed [W-1:0] bx, by, bz;
  logic signed [W:0]   dx, dy, dz;
  logic [SW-1:0]       prod, sum, rad;
  logic [W+1:0]        rem;  // never exceeds twice the partial root
  logic [W:0]          root;

  logic signed [W:0] dsel;
  logic [W:0]        magv;
  logic [SW-1:0]     sq_w;
  logic [W+3:0]      rem_sh, trial, diff;

  always_comb begin
    case (cmd.sel)
      pdd_pkg::AXIS_X: dsel = dx;
      pdd_pkg::AXIS_Y: dsel = dy;
      pdd_pkg::AXIS_Z: dsel = dz;
      default:         dsel = dz;
    endcase
  end

  // magnitude of -2^W is 2^W, which still fits W+1 unsigned bits
  assign magv = dsel[W] ? (W+1)'(-dsel) : dsel;
  assign sq_w = SW'(magv) * SW'(magv);

  assign rem_sh = {rem, rad[SW-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
      last_z <= '0;
    end else if (cmd.flush) begin
      last_x <= '0;
      last_y <= '0;
      last_z <= '0;
    end else if (cmd.load) begin
      last_x <= x_coord;
      last_y <= y_coord;
      last_z <= z_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_r <= tag;
      bx    <= last_x;
      by    <= last_y;
      bz    <= last_z;
      dx    <= {x_coord[W-1], x_coord} - {last_x[W-1], last_x};
      dy    <= {y_coord[W-1], y_coord} - {last_y[W-1], last_y};
      dz    <= {z_coord[W-1], z_coord} - {last_z[W-1], last_z};
      prod  <= '0;
      sum   <= '0;
    end else if (cmd.square) begin
      prod <= sq_w;
      sum  <= sum + prod;
    end

    if (cmd.root_init) begin
      rad  <= sum + prod;
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad <= {rad[SW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= diff[W+1:0];
        root <= {root[W-1:0], 1'b1};
      end else begin
        rem  <= rem_sh[W+1:0];
        root <= {root[W-1:0], 1'b0};
      end
    end

    if (cmd.out_load) begin
      tag_out      <= tag_r;
      before_x     <= bx;
      before_y     <= by;
      before_z     <= bz;
      rising_flags <= {!dz[W], !dy[W], !dx[W]};
      delta_x      <= dx;
      delta_y      <= dy;
      delta_z      <= dz;
      distance     <= root;
    end
  end

endmodule

[sv/point_motion_delta_distance.sv]
// Top level of the point motion delta and distance block.
`timescale 1ns / 1ps
// Each sample item (func = 0) yields one result: its tag, the stored previous
// point, per-axis deltas (current minus previous), a flag per axis set where
// the delta is not negative, and floor(sqrt(dx^2 + dy^2 + dz^2)) in the same
// fixed-point format as the coordinates. The sample then becomes the stored
// point. A flush item (func = 1) zeroes the stored point and gives no result.
// A sample is captured, then squared on the shared squarer that handles one
// axis per cycle, then passed through the restoring square root that resolves
// one result bit per cycle, and finally loaded into the output register once
// that register is free. The input accepts only between samples; a finished
// result waits in the output register while the next item is taken in and
// worked on.
module point_motion_delta_distance #(
  parameter int COORD_WIDTH = pdd_pkg::COORD_WIDTH
) (
  input logic              clk,
  input logic              rst,
  pdd_sample_if.sink       sample,
  pdd_result_if.source     result
);

  pdd_pkg::cmd_t cmd;

  pdd_ctrl #(.W(COORD_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_func   (sample.func),
    .in_ready  (sample.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd)
  );

  pdd_datapath #(.W(COORD_WIDTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .tag          (sample.tag),
    .x_coord      (sample.x_coord),
    .y_coord      (sample.y_coord),
    .z_coord      (sample.z_coord),
    .tag_out      (result.tag_out),
    .before_x     (result.before_x),
    .before_y     (result.before_y),
    .before_z     (result.before_z),
    .rising_flags (result.rising_flags),
    .delta_x      (result.delta_x),
    .delta_y      (result.delta_y),
    .delta_z      (result.delta_z),
    .distance     (result.distance)
  );

endmodule

[sv/pdd_checker.sv]
// Port-level checks for the point motion block, bound to the top level.
`timescale 1ns / 1ps
module pdd_checker #(
  parameter int W = pdd_pkg::COORD_WIDTH
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pdd_pkg::NUM_AXES-1:0]  rising_flags,
  input logic signed [W:0]             delta_x,
  input logic signed [W:0]             delta_y,
  input logic signed [W:0]             delta_z,
  input logic [W:0]                    distance
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // a sample keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_func == pdd_pkg::FUNC_SAMPLE |=> !in_ready)
    else $error("input ready right after a sample item");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rising_flags[0] == !delta_x[W] && rising_flags[1] == !delta_y[W]
                  && rising_flags[2] == !delta_z[W])
    else $error("flags disagree with delta signs");

  a_same_point: assert property (@(posedge clk) disable iff (rst)
    out_valid && delta_x == '0 && delta_y == '0 && delta_z == '0 |-> distance == '0)
    else $error("nonzero distance between equal points");

endmodule

bind point_motion_delta_distance pdd_checker #(.W(COORD_WIDTH)) u_pdd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .in_func      (sample.func),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .rising_flags (result.rising_flags),
  .delta_x      (result.delta_x),
  .delta_y      (result.delta_y),
  .delta_z      (result.delta_z),
  .distance     (result.distance)
);

[bench/point_motion_delta_distance_tb.sv]
// Self-checking testbench for point_motion_delta_distance: deltas, flags and distance.
`timescale 1ns / 1ps
module point_motion_delta_distance_tb;

  localparam int CW           = pdd_pkg::COORD_WIDTH;
  localparam int TW           = pdd_pkg::TAG_WIDTH;
  localparam int STALL_LIMIT  = 3000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic                 func;
    logic signed [TW-1:0] tag;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } point_item_t;

  typedef struct packed {
    logic signed [TW-1:0] tag;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic [2:0]           flags;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic signed [CW:0]   dz;
    logic [CW:0]          span;
  } motion_step_t;

  class motion_scoreboard;
    logic signed [CW-1:0] last_x;
    logic signed [CW-1:0] last_y;
    logic signed [CW-1:0] last_z;
    motion_step_t         expected_steps[$];
    int                   errors;
    int                   n_samples;
    int                   n_flushes;
    int                   n_checked;
    longint               max_dist;

    function new();
      last_x = '0;
      last_y = '0;
      last_z = '0;
      errors = 0;
      n_samples = 0;
      n_flushes = 0;
      n_checked = 0;
      max_dist = 0;
    endfunction

    // floor(sqrt(v)), one result bit at a time from the top
    function longint unsigned floor_root(longint unsigned v);
      longint unsigned root;
      longint unsigned cand;
      root = 0;
      for (int b = CW + 1; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand * cand <= v) root = cand;
      end
      return root;
    endfunction

    function motion_step_t predict_step(point_item_t s);
      motion_step_t r;
      longint ax;
      longint ay;
      longint az;
      r.tag = s.tag;
      r.bx = last_x;
      r.by = last_y;
      r.bz = last_z;
      // exact in CW+1 bits, so modular subtraction of sign-extended values is fine
      r.dx = {s.x[CW-1], s.x} - {last_x[CW-1], last_x};
      r.dy = {s.y[CW-1], s.y} - {last_y[CW-1], last_y};
      r.dz = {s.z[CW-1], s.z} - {last_z[CW-1], last_z};
      r.flags = {~r.dz[CW], ~r.dy[CW], ~r.dx[CW]};
      ax = longint'(r.dx);
      ay = longint'(r.dy);
      az = longint'(r.dz);
      r.span = (CW+1)'(floor_root(ax * ax + ay * ay + az * az));
      return r;
    endfunction

    function void note_item(point_item_t s);
      motion_step_t r;
      if (s.func == pdd_pkg::FUNC_FLUSH) begin
        last_x = '0;
        last_y = '0;
        last_z = '0;
        n_flushes++;
        return;
      end
      r = predict_step(s);
      expected_steps.push_back(r);
      if (longint'(r.span) > max_dist) max_dist = longint'(r.span);
      last_x = s.x;
      last_y = s.y;
      last_z = s.z;
      n_samples++;
    endfunction

    function void compare_field(string name, longint want, longint got, longint tag);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch (tag %0d): expected %0d, actual %0d",
                 $time, name, tag, want, got);
      end
    endfunction

    function void check_step(motion_step_t got);
      motion_step_t want;
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending: expected none, actual tag %0d distance %0d",
                 $time, got.tag, got.span);
        return;
      end
      want = expected_steps.pop_front();
      n_checked++;
      compare_field("tag_out", want.tag, got.tag, want.tag);
      compare_field("before_x", want.bx, got.bx, want.tag);
      compare_field("before_y", want.by, got.by, want.tag);
      compare_field("before_z", want.bz, got.bz, want.tag);
      compare_field("rising_flags", want.flags, got.flags, want.tag);
      compare_field("delta_x", want.dx, got.dx, want.tag);
      compare_field("delta_y", want.dy, got.dy, want.tag);
      compare_field("delta_z", want.dz, got.dz, want.tag);
      compare_field("distance", want.span, got.span, want.tag);
    endfunction

    function int pending();
      return expected_steps.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  pdd_sample_if #(.W(CW)) sample_ch ();
  pdd_result_if #(.W(CW)) result_ch ();

  point_motion_delta_distance #(.COORD_WIDTH(CW)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  motion_scoreboard sb;
  motion_step_t     observed;
  int               send_idle_pct;
  int               stall_pct;
  int               idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_len();
    return ($urandom_range(9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic point_item_t mk(logic f, int tag, int x, int y, int z);
    point_item_t s;
    s.func = f;
    s.tag = TW'(tag);
    s.x = CW'(x);
    s.y = CW'(y);
    s.z = CW'(z);
    return s;
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(int style, logic signed [CW-1:0] prev);
    int r;
    r = $urandom_range(4);
    case (style)
      0: return CW'($urandom);
      1: return prev + CW'($urandom_range(0, 64) - 32);
      2: return prev;
      3: begin
        case (r)
          0: return {1'b1, {(CW-1){1'b0}}};
          1: return {1'b0, {(CW-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return CW'(1);
        endcase
      end
      default: return CW'($urandom_range(0, 1023) - 512);
    endcase
  endfunction

  function automatic point_item_t random_item();
    point_item_t s;
    int roll;
    int style;
    roll = $urandom_range(99);
    if (roll < 40) style = 0;
    else if (roll < 60) style = 1;
    else if (roll < 70) style = 2;
    else if (roll < 85) style = 3;
    else style = 4;
    s.func = ($urandom_range(99) < 12) ? pdd_pkg::FUNC_FLUSH : pdd_pkg::FUNC_SAMPLE;
    s.tag = TW'($urandom);
    s.x = pick_coord(style, sb.last_x);
    s.y = pick_coord(style, sb.last_y);
    s.z = pick_coord(style, sb.last_z);
    return s;
  endfunction

  // entered right after a posedge; returns at the posedge that accepts the item
  task automatic send_item(point_item_t s);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? pick_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      sample_ch.valid = 1'b0;
      sample_ch.func = 1'($urandom_range(1));
      sample_ch.tag = TW'($urandom);
      sample_ch.x_coord = CW'($urandom);
      sample_ch.y_coord = CW'($urandom);
      sample_ch.z_coord = CW'($urandom);
      repeat (gap) @(negedge clk);
    end
    sample_ch.func = s.func;
    sample_ch.tag = s.tag;
    sample_ch.x_coord = s.x;
    sample_ch.y_coord = s.y;
    sample_ch.z_coord = s.z;
    sample_ch.valid = 1'b1;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_item(s);
  endtask

  task automatic send_random(int count);
    repeat (count) send_item(random_item());
  endtask

  // result side: random back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    result_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ch.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(99) < stall_pct) begin
        result_ch.ready = 1'b0;
        stall_left = pick_len() - 1;
      end else begin
        result_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      observed.tag = result_ch.tag_out;
      observed.bx = result_ch.before_x;
      observed.by = result_ch.before_y;
      observed.bz = result_ch.before_z;
      observed.flags = result_ch.rising_flags;
      observed.dx = result_ch.delta_x;
      observed.dy = result_ch.delta_y;
      observed.dz = result_ch.delta_z;
      observed.span = result_ch.distance;
      sb.check_step(observed);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, sb.pending());
      $display("point_motion_delta_distance_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sb = new();
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    sample_ch.valid = 1'b0;
    sample_ch.func = pdd_pkg::FUNC_SAMPLE;
    sample_ch.tag = '0;
    sample_ch.x_coord = '0;
    sample_ch.y_coord = '0;
    sample_ch.z_coord = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // directed: reset point, extremes, equal points, flushes
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 0, 0, 0, 0));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 32767, 32767, 32767, 32767));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, -32768, -32768, -32768, -32768));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, -1, 32767, -32768, 32767));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 1, 32767, -32768, 32767));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 'h1234, -32768, 32767, -32768));
    send_item(mk(pdd_pkg::FUNC_FLUSH, 32767, 'h5555, -1, 'h2aaa));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 2, -32768, -32768, -32768));
    send_item(mk(pdd_pkg::FUNC_FLUSH, 0, 0, 0, 0));
    send_item(mk(pdd_pkg::FUNC_FLUSH, -32768, 32767, 32767, 32767));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 3, 0, 0, 0));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 4, 256, 0, 0));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 5, 256, 256, 256));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 6, -1, -1, -1));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 7, 1, -1, 0));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 8, 'h00ff, 'h7f00, -256));
    send_item(mk(pdd_pkg::FUNC_FLUSH, 9, -1, -1, -1));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 10, 32767, 32767, 32767));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 11, -32768, 32767, 0));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 12, 0, 0, -32768));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 13, 'haaaa, 'h5555, 'haaaa));
    send_item(mk(pdd_pkg::FUNC_SAMPLE, 14, 'h5555, 'haaaa, 'h5555));

    send_idle_pct = 30;
    stall_pct = 8;
    send_random(300);
    send_idle_pct = 0;
    stall_pct = 0;
    send_random(75);
    send_idle_pct = 60;
    stall_pct = 25;
    send_random(75);

    @(negedge clk);
    sample_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d point samples and %0d flushes; %0d results checked.",
             sb.n_samples, sb.n_flushes, sb.n_checked);
    $display("Largest distance seen %0d, with extreme, equal and random points.",
             sb.max_dist);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("point_motion_delta_distance_tb passed");
    end else begin
      $display("point_motion_delta_distance_tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
sv/pdd_pkg.sv
sv/pdd_sample_if.sv
sv/pdd_result_if.sv
sv/pdd_ctrl.sv
sv/pdd_datapath.sv
sv/point_motion_delta_distance.sv
sv/pdd_checker.sv
bench/point_motion_delta_distance_tb.sv
